@@ rtl/core/tkdl_pkg.sv @@
// Shared types and constants for the touch key debounce latch.
package tkdl_pkg;

  // Number of debounced key patterns and their flag positions.
  localparam int unsigned NumPatterns = 5;
  localparam int unsigned IdxHot      = 0;
  localparam int unsigned IdxWarm     = 1;
  localparam int unsigned IdxCold     = 2;
  localparam int unsigned IdxHotlock  = 3;
  localparam int unsigned IdxAllon    = 4;

  // Field widths.
  localparam int unsigned KeyW   = 4;
  localparam int unsigned DelayW = 8;
  localparam int unsigned LockW  = 16;

  // Active-low key patterns (low nibble of the sampled byte).
  localparam logic [KeyW-1:0] KEYS_HOTLOCK = 4'hE;
  localparam logic [KeyW-1:0] KEYS_HOT     = 4'hD;
  localparam logic [KeyW-1:0] KEYS_WARM    = 4'hB;
  localparam logic [KeyW-1:0] KEYS_COLD    = 4'h7;
  localparam logic [KeyW-1:0] KEYS_ALLON   = 4'h8;
  localparam logic [KeyW-1:0] KEYS_RELEASE = 4'hF;

  // Operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ACK    = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PRESS_DELAY   = 1'b0;
  localparam logic CFG_COMBO_LOCKOUT = 1'b1;

  // Configuration reset values.
  localparam logic [DelayW-1:0] PRESS_DELAY_RST   = 8'd2;
  localparam logic [LockW-1:0]  COMBO_LOCKOUT_RST = 16'd300;

  // Configuration values handed to the update logic.
  typedef struct packed {
    logic [DelayW-1:0] press_delay;
    logic [LockW-1:0]  combo_lockout;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic                   operation;
    logic [KeyW-1:0]        keys;
    logic [NumPatterns-1:0] ack_mask;
  } item_t;

  // One result word: press flags and the lock.
  typedef struct packed {
    logic [NumPatterns-1:0] flags;
    logic                   locked;
  } result_t;

endpackage

@@ rtl/core/tkdl_cfg.sv @@
// Configuration registers for the touch key debounce latch.
module tkdl_cfg
  import tkdl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [LockW-1:0]  cfg_data_i,
  output cfg_t              cfg_o
);

  logic [DelayW-1:0] press_delay_q;
  logic [LockW-1:0]  combo_lockout_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_delay_q   <= PRESS_DELAY_RST;
      combo_lockout_q <= COMBO_LOCKOUT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESS_DELAY:   press_delay_q   <= cfg_data_i[DelayW-1:0];
        CFG_COMBO_LOCKOUT: combo_lockout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.press_delay   = press_delay_q;
  assign cfg_o.combo_lockout = combo_lockout_q;

endmodule

@@ rtl/core/tkdl_update.sv @@
// Debounce state and its update for each word.
module tkdl_update
  import tkdl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic [DelayW-1:0]      cnt_q [NumPatterns];
  logic [DelayW-1:0]      cnt_d [NumPatterns];
  logic [LockW-1:0]       other_q, other_d;
  logic [NumPatterns-1:0] flags_q, flags_d;
  logic                   lock_q, lock_d;

  logic [NumPatterns-1:0] match;
  logic [NumPatterns-1:0] cnt_zero;
  logic                   is_sample;
  logic                   is_release;
  logic                   is_other;
  logic                   other_expired;
  logic                   latch;

  // Decode the sampled key pattern.
  always_comb begin
    match             = '0;
    match[IdxHotlock] = (item_i.keys == KEYS_HOTLOCK);
    match[IdxHot]     = (item_i.keys == KEYS_HOT);
    match[IdxWarm]    = (item_i.keys == KEYS_WARM);
    match[IdxCold]    = (item_i.keys == KEYS_COLD);
    match[IdxAllon]   = (item_i.keys == KEYS_ALLON);
  end

  assign is_sample     = (item_i.operation == OP_SAMPLE);
  assign is_release    = is_sample && (item_i.keys == KEYS_RELEASE);
  assign is_other      = is_sample && !is_release && (match == '0);
  assign other_expired = is_other && (other_q == '0);

  // A held pattern whose counter has run out latches if the lock is clear.
  always_comb begin
    for (int i = 0; i < NumPatterns; i++) begin
      cnt_zero[i] = (cnt_q[i] == '0);
    end
  end
  assign latch = is_sample && ((match & cnt_zero) != '0) && !lock_q;

  // Pattern counters.
  always_comb begin
    for (int i = 0; i < NumPatterns; i++) begin
      cnt_d[i] = cnt_q[i];
      if (is_release || other_expired) begin
        cnt_d[i] = cfg_i.press_delay;
      end else if (is_sample && match[i] && !cnt_zero[i]) begin
        cnt_d[i] = cnt_q[i] - 1'b1;
      end
    end
  end

  // Lockout counter, flags and lock.
  always_comb begin
    other_d = other_q;
    flags_d = flags_q;
    lock_d  = lock_q;
    if (!is_sample) begin
      flags_d = flags_q & ~item_i.ack_mask;
    end else if (is_release) begin
      other_d = cfg_i.combo_lockout;
      flags_d = '0;
      lock_d  = 1'b0;
    end else if (latch) begin
      flags_d = flags_q | match;
      lock_d  = 1'b1;
    end else if (other_expired) begin
      lock_d = 1'b1;
    end else if (is_other) begin
      other_d = other_q - 1'b1;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPatterns; i++) begin
        cnt_q[i] <= '0;
      end
      other_q <= '0;
      flags_q <= '0;
      lock_q  <= 1'b0;
    end else if (step_i) begin
      for (int i = 0; i < NumPatterns; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      other_q <= other_d;
      flags_q <= flags_d;
      lock_q  <= lock_d;
    end
  end

  // The result shows the state after this word.
  assign result_o.flags  = flags_d;
  assign result_o.locked = lock_d;

endmodule

@@ rtl/core/touch_key_debounce_latch_unit.sv @@
// Top level of the touch key debounce latch with chord lockout.
//
// Input channel (in_valid_i / in_ready_o) carries one word per sample tick
// or acknowledge: operation_i, keys_i (active low) and ack_mask_i.
// Output channel (out_valid_o / out_ready_i) returns one word for every
// input word: the five latched press flags and press_locked, as they stand
// after that word.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes press_delay
// (index 0) or combo_lockout (index 1); it is always ready. It is to be
// written only while the block is idle; the block does not enforce this.
// A word passes through the input register, then through the state update
// into the output register. Throughput is one word per cycle while the
// output is not stalled.
// Reset clears all counters, flags and the lock, and loads press_delay = 2
// and combo_lockout = 300. When the receiver stalls, the output register
// holds its word, the input register still fills, and in_ready_o drops only
// once both are occupied.
module touch_key_debounce_latch_unit
  import tkdl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic [KeyW-1:0]        keys_i,
  input  logic [NumPatterns-1:0] ack_mask_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   hot_pressed_o,
  output logic                   warm_pressed_o,
  output logic                   cold_pressed_o,
  output logic                   hotlock_pressed_o,
  output logic                   allon_pressed_o,
  output logic                   press_locked_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [LockW-1:0]       cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;

  // Configuration registers.
  tkdl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow control.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.operation <= operation_i;
      in_q.keys      <= keys_i;
      in_q.ack_mask  <= ack_mask_i;
    end
  end

  // State update.
  tkdl_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign hot_pressed_o     = res_q.flags[IdxHot];
  assign warm_pressed_o    = res_q.flags[IdxWarm];
  assign cold_pressed_o    = res_q.flags[IdxCold];
  assign hotlock_pressed_o = res_q.flags[IdxHotlock];
  assign allon_pressed_o   = res_q.flags[IdxAllon];
  assign press_locked_o    = res_q.locked;

endmodule
